>>> rtl/core/sm3he_pkg.sv
// ----------------------------------------------------------------------------
// sm3he_pkg
// Shared types, constants and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
package sm3he_pkg;

  // eight 32-bit words, element 0 is word A / digest word 0
  typedef logic [7:0][31:0] word8_t;

  localparam word8_t SM3_IV = {
    32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
    32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
  };

  localparam logic [31:0] TJ_LOW   = 32'h79cc4519;
  localparam logic [31:0] TJ_HIGH  = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_FEED  = 6'b001000,
    ST_LEN   = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic       wr_byte;
    logic       pad;
    logic       len_load;
    logic       shift;
    logic [5:0] fill;
    logic [7:0] data;
  } sched_ctrl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    return (x << n) | (x >> (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  function automatic logic [31:0] tconst(input logic [5:0] j);
    return rotl((j[5:4] == 2'b00) ? TJ_LOW : TJ_HIGH, j[4:0]);
  endfunction

endpackage

>>> rtl/core/sm3_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sm3_hash_engine_unit
// SM3 (256-bit) hash engine, byte stream in, digest words out.
// ----------------------------------------------------------------------------
// Input: one transaction per byte. s_axis_tdata carries the byte, s_axis_tuser
// says the byte is part of the message, s_axis_tlast ends the message (it may
// carry no byte, so an empty message works).
// Output: eight 32-bit digest words per message, word 0 first, each the
// big-endian reading of four digest bytes; m_axis_tlast marks word 7.
// Flow: a byte that does not complete a 64-byte block is taken while the input
// stays ready. A byte that completes a block starts a compression: load, 64
// rounds on the shared round unit (one per cycle), then feed-forward. A message
// end adds padding and one more compression, or two padded blocks when 56 or more
// bytes sit in the last block; ST_DONE then moves the digest into the output buffer.
// The digest leaves from its own buffer, so the next message is taken while
// the words drain. If the receiver stalls and the buffer is still full at the
// next message end, the engine waits with s_axis_tready low.
// Reset: synchronous, returns to the initial value, empty block, length zero,
// and an empty output buffer.
// ----------------------------------------------------------------------------
module sm3_hash_engine_unit
  import sm3he_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // byte_valid
  input  logic        s_axis_tlast,   // msg_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic        m_axis_tlast    // word_last
);

  state_t      state;
  logic [5:0]  fill;
  logic [60:0] total;
  logic [5:0]  jcnt;
  logic        pend_end;
  logic        last_blk;
  logic        need_len;
  word8_t      chain;
  word8_t      obuf;
  logic [2:0]  ocnt;
  logic        obusy;

  logic        in_acc;
  logic        out_acc;
  logic        wr_byte;
  logic        blk_full;
  logic        load_rnd;
  sched_ctrl_t sctrl;
  logic [31:0] w_j, wp_j;
  word8_t      v;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign wr_byte       = in_acc & s_axis_tuser;
  assign blk_full      = wr_byte & (fill == 6'd63);
  assign load_rnd      = blk_full | (state == ST_PAD) | (state == ST_LEN);

  assign m_axis_tvalid = obusy;
  assign m_axis_tdata  = obuf[0];
  assign m_axis_tlast  = (ocnt == 3'd7);
  assign out_acc       = m_axis_tvalid & m_axis_tready;

  assign sctrl.wr_byte  = wr_byte;
  assign sctrl.pad      = (state == ST_PAD);
  assign sctrl.len_load = (state == ST_LEN);
  assign sctrl.shift    = (state == ST_ROUND);
  assign sctrl.fill     = fill;
  assign sctrl.data     = s_axis_tdata;

  sm3he_msg_sched u_sched (
    .clk     (clk),
    .ctrl    (sctrl),
    .bit_len ({total, 3'b000}),
    .w_j     (w_j),
    .wp_j    (wp_j)
  );

  sm3he_round u_round (
    .clk   (clk),
    .load  (load_rnd),
    .step  (state == ST_ROUND),
    .j     (jcnt),
    .chain (chain),
    .w_j   (w_j),
    .wp_j  (wp_j),
    .v     (v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      fill     <= '0;
      total    <= '0;
      jcnt     <= '0;
      pend_end <= 1'b0;
      last_blk <= 1'b0;
      need_len <= 1'b0;
      chain    <= SM3_IV;
      ocnt     <= '0;
      obusy    <= 1'b0;
    end else begin
      if (load_rnd) begin
        jcnt <= '0;
      end else if (state == ST_ROUND) begin
        jcnt <= jcnt + 6'd1;
      end

      if (out_acc) begin
        obuf <= obuf >> 32;
        ocnt <= ocnt + 3'd1;
        if (ocnt == 3'd7) begin
          obusy <= 1'b0;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            pend_end <= s_axis_tlast;
            if (wr_byte) begin
              fill  <= fill + 6'd1;
              total <= total + 61'd1;
            end
            if (blk_full) begin
              last_blk <= 1'b0;
              need_len <= 1'b0;
              state    <= ST_ROUND;
            end else if (s_axis_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          last_blk <= (fill[5:3] != 3'b111);
          need_len <= (fill[5:3] == 3'b111);
          state    <= ST_ROUND;
        end
        ST_ROUND: begin
          if (jcnt == 6'd63) begin
            state <= ST_FEED;
          end
        end
        ST_FEED: begin
          chain <= chain ^ v;
          fill  <= '0;
          if (last_blk) begin
            state <= ST_DONE;
          end else if (need_len) begin
            state <= ST_LEN;
          end else if (pend_end) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_LEN: begin
          last_blk <= 1'b1;
          need_len <= 1'b0;
          state    <= ST_ROUND;
        end
        ST_DONE: begin
          if (!obusy) begin
            obuf     <= chain;
            ocnt     <= '0;
            obusy    <= 1'b1;
            chain    <= SM3_IV;
            total    <= '0;
            fill     <= '0;
            pend_end <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/sm3he_msg_sched.sv
// ----------------------------------------------------------------------------
// sm3he_msg_sched
// Block buffer and message expansion window: collects bytes, pads, then
// shifts out W[j] / W'[j] one word per round.
// ----------------------------------------------------------------------------
module sm3he_msg_sched
  import sm3he_pkg::*;
(
  input  logic        clk,
  input  sched_ctrl_t ctrl,
  input  logic [63:0] bit_len,
  output logic [31:0] w_j,
  output logic [31:0] wp_j
);

  logic [31:0] w [16];
  logic [31:0] w_new;
  logic [31:0] pad_word;
  logic [3:0]  widx;
  logic        len_fits;

  assign widx     = ctrl.fill[5:2];
  assign len_fits = (ctrl.fill[5:3] != 3'b111);

  assign w_new = perm1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
  assign w_j   = w[0];
  assign wp_j  = w[0] ^ w[4];

  // partial word: keep bytes before the pad position, then 0x80, then zeros
  always_comb begin
    pad_word = '0;
    for (int b = 0; b < 4; b++) begin
      if (2'(b) < ctrl.fill[1:0]) begin
        pad_word[(3 - b) * 8 +: 8] = w[widx][(3 - b) * 8 +: 8];
      end else if (2'(b) == ctrl.fill[1:0]) begin
        pad_word[(3 - b) * 8 +: 8] = PAD_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_byte) begin
      for (int k = 0; k < 16; k++) begin
        if (4'(k) == widx) begin
          w[k][{~ctrl.fill[1:0], 3'b000} +: 8] <= ctrl.data;
        end
      end
    end else if (ctrl.pad) begin
      for (int k = 0; k < 16; k++) begin
        if (4'(k) == widx) begin
          w[k] <= pad_word;
        end else if (4'(k) > widx) begin
          if (len_fits && k == 14) begin
            w[k] <= bit_len[63:32];
          end else if (len_fits && k == 15) begin
            w[k] <= bit_len[31:0];
          end else begin
            w[k] <= '0;
          end
        end
      end
    end else if (ctrl.len_load) begin
      for (int k = 0; k < 14; k++) begin
        w[k] <= '0;
      end
      w[14] <= bit_len[63:32];
      w[15] <= bit_len[31:0];
    end else if (ctrl.shift) begin
      for (int k = 0; k < 15; k++) begin
        w[k] <= w[k + 1];
      end
      w[15] <= w_new;
    end
  end

endmodule

>>> rtl/core/sm3he_round.sv
// ----------------------------------------------------------------------------
// sm3he_round
// Shared compression round: working variables A..H, one round per step.
// ----------------------------------------------------------------------------
module sm3he_round
  import sm3he_pkg::*;
(
  input  logic        clk,
  input  logic        load,
  input  logic        step,
  input  logic [5:0]  j,
  input  word8_t      chain,
  input  logic [31:0] w_j,
  input  logic [31:0] wp_j,
  output word8_t      v
);

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        early;

  assign early = (j[5:4] == 2'b00);
  assign a12   = rotl(v[0], 5'd12);
  assign ss1   = rotl(a12 + v[4] + tconst(j), 5'd7);
  assign ss2   = ss1 ^ a12;
  assign ff    = early ? (v[0] ^ v[1] ^ v[2]) :
                 ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
  assign gg    = early ? (v[4] ^ v[5] ^ v[6]) : ((v[4] & v[5]) | (~v[4] & v[6]));
  assign tt1   = ff + v[3] + ss2 + wp_j;
  assign tt2   = gg + v[7] + ss1 + w_j;

  always_ff @(posedge clk) begin
    if (load) begin
      v <= chain;
    end else if (step) begin
      v[0] <= tt1;
      v[1] <= v[0];
      v[2] <= rotl(v[1], 5'd9);
      v[3] <= v[2];
      v[4] <= perm0(tt2);
      v[5] <= v[4];
      v[6] <= rotl(v[5], 5'd19);
      v[7] <= v[6];
    end
  end

endmodule

>>> rtl/core/sm3he_checker.sv
// ----------------------------------------------------------------------------
// sm3he_checker
// Port-level checks of the SM3 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module sm3he_checker
  import sm3he_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // output buffer empty after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("digest output valid right after reset");

  // message end transaction closes the input next cycle (padding or compression follows)
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input ready right after message end");

  // a full block keeps the input closed while it compresses
  a_block_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) ##1 !s_axis_tready
      |-> ##1 !s_axis_tready)
    else $error("input reopened during block compression");

  // last digest word empties the buffer
  a_last_drain: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("digest output valid right after last word");

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled digest transaction changed");

endmodule

bind sm3_hash_engine_unit sm3he_checker u_sm3he_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the SM3 byte-stream hash engine. A short table of
// directed transactions (empty message, "abc", ignored beats, extreme bytes)
// is followed by random messages under four source/sink throttling phases.
// Digest words are matched to a behavioral SM3 predictor or a table digest.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [255:0] IV_WORDS =
    256'h7380166f_4914b2b9_172442d7_da8a0600_a96f30bc_163138aa_e38dee4d_b0fb0e4e;
  localparam logic [31:0]  ROUND_K_LO = 32'h79cc4519;
  localparam logic [31:0]  ROUND_K_HI = 32'h7a879d8a;
  localparam logic [7:0]   MSG_PAD    = 8'h80;
  localparam logic [255:0] DIGEST_EMPTY =
    256'h1ab21d83_55cfa17f_8e611948_31e81a8f_22bec8c7_28fefb74_7ed035eb_5082aa2b;
  localparam logic [255:0] DIGEST_ABC =
    256'h66c7f0f4_62eeedd9_d1f2d46b_dc10e4e2_4167c487_5cf2f7a2_297da02b_8f4ba8e0;
  localparam int PHASE_ITEMS = 66;

  typedef struct packed {
    logic [7:0]   data;
    logic         has_byte;
    logic         ends;
    logic         known;
    logic [255:0] digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;

  digest_beat_t digest_exp_q[$];

  // predictor state
  logic [31:0] hash_v [8];
  logic [7:0]  blk_buf [64];
  int          blk_fill;
  logic [60:0] msg_bytes;

  stim_row_t dir_tab [0:14] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
    '{8'h00, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'ha5, 1'b0, 1'b1, 1'b0, 256'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 256'h0},
    '{8'h3c, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    '{8'h80, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, 256'h0},
    '{8'h01, 1'b1, 1'b1, 1'b0, 256'h0}
  };

  sm3_hash_engine_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
    int s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] mix_p0(input logic [31:0] x);
    return x ^ rot_left(x, 9) ^ rot_left(x, 17);
  endfunction

  function automatic logic [31:0] mix_p1(input logic [31:0] x);
    return x ^ rot_left(x, 15) ^ rot_left(x, 23);
  endfunction

  function automatic void restart_chain();
    int k;
    for (k = 0; k < 8; k++) hash_v[k] = IV_WORDS[255 - 32 * k -: 32];
    blk_fill = 0;
    msg_bytes = '0;
  endfunction

  function automatic void compress_blk();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] ss1, ss2, ff, gg, tt1, tt2;
    int j;
    for (j = 0; j < 16; j++)
      w[j] = {blk_buf[4*j], blk_buf[4*j+1], blk_buf[4*j+2], blk_buf[4*j+3]};
    for (j = 16; j < 68; j++)
      w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15)) ^
             rot_left(w[j-13], 7) ^ w[j-6];
    a = hash_v[0]; b = hash_v[1]; c = hash_v[2]; d = hash_v[3];
    e = hash_v[4]; f = hash_v[5]; g = hash_v[6]; h = hash_v[7];
    for (j = 0; j < 64; j++) begin
      ss1 = rot_left(rot_left(a, 12) + e +
                     rot_left((j < 16) ? ROUND_K_LO : ROUND_K_HI, j), 7);
      ss2 = ss1 ^ rot_left(a, 12);
      ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
      gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rot_left(b, 9); b = a; a = tt1;
      h = g; g = rot_left(f, 19); f = e; e = mix_p0(tt2);
    end
    hash_v[0] ^= a; hash_v[1] ^= b; hash_v[2] ^= c; hash_v[3] ^= d;
    hash_v[4] ^= e; hash_v[5] ^= f; hash_v[6] ^= g; hash_v[7] ^= h;
  endfunction

  // returns 1 when the transaction closes a message; dg holds the digest
  function automatic bit sm3_take(input logic [7:0] d, input logic v, input logic e,
                                  output logic [255:0] dg);
    logic [63:0] bit_len;
    int i;
    dg = '0;
    if (v) begin
      blk_buf[blk_fill] = d;
      msg_bytes = msg_bytes + 61'd1;
      blk_fill++;
      if (blk_fill == 64) begin
        compress_blk();
        blk_fill = 0;
      end
    end
    if (!e) return 1'b0;
    bit_len = {msg_bytes, 3'b000};
    blk_buf[blk_fill] = MSG_PAD;
    for (i = blk_fill + 1; i < 64; i++) blk_buf[i] = 8'h00;
    if (blk_fill >= 56) begin
      compress_blk();
      for (i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    end
    for (i = 0; i < 8; i++) blk_buf[63 - i] = bit_len[8*i +: 8];
    compress_blk();
    for (i = 0; i < 8; i++) dg[255 - 32 * i -: 32] = hash_v[i];
    restart_chain();
    return 1'b1;
  endfunction

  task automatic put_item(input logic [7:0] d, input logic v, input logic e,
                          input logic known, input logic [255:0] typed);
    logic [255:0] dg;
    logic [255:0] use_dg;
    bit fin;
    int k;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= v;
    s_tlast  <= e;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fin = sm3_take(d, v, e, dg);
    if (fin) begin
      use_dg = known ? typed : dg;
      for (k = 0; k < 8; k++)
        digest_exp_q.push_back('{word: use_dg[255 - 32 * k -: 32], last: (k == 7)});
    end
    if (v || e) items_sent++;
  endtask

  task automatic send_message(input int len);
    bit end_on_byte;
    int i;
    end_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 6)
        put_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
      put_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1), 1'b0, '0);
    end
    if (!end_on_byte) put_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
  endtask

  always @(posedge clk) begin : digest_check
    digest_beat_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
      if (m_tvalid && m_tready) begin
        if (digest_exp_q.size() == 0) begin
          $error("unexpected digest transaction: digest_word %h word_last %b",
                 m_tdata, m_tlast);
          mismatches++;
        end else begin
          want = digest_exp_q.pop_front();
          if (m_tdata !== want.word) begin
            $error("digest_word mismatch: expected %h actual %h", want.word, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("word_last mismatch: expected %b actual %b", want.last, m_tlast);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int phase;
    int len;
    int r;
    int i;
    int base;
    bit first;
    restart_chain();
    for (i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < 15; i++)
      put_item(dir_tab[i].data, dir_tab[i].has_byte, dir_tab[i].ends,
               dir_tab[i].known, dir_tab[i].digest);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 78; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 78; end
        default: begin src_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      base = items_sent;
      first = 1'b1;
      while (items_sent - base < PHASE_ITEMS) begin
        r = $urandom_range(9);
        if (first && phase == 0)      len = 56;
        else if (first && phase == 1) len = 64;
        else if (first && phase == 2) len = 55;
        else if (r < 3)               len = $urandom_range(12);
        else if (r < 7)               len = $urandom_range(72, 50);
        else                          len = $urandom_range(140);
        if (!first && len > PHASE_ITEMS - (items_sent - base))
          len = PHASE_ITEMS - (items_sent - base);
        first = 1'b0;
        send_message(len);
      end
    end
    s_tvalid <= 1'b0;

    while (digest_exp_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sm3he_pkg.sv
rtl/core/sm3he_msg_sched.sv
rtl/core/sm3he_round.sv
rtl/core/sm3_hash_engine_unit.sv
rtl/core/sm3he_checker.sv
bench/testbench.sv
